/* design/wfp_pkg.sv */
package wfp_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int COLOUR_W       = 12;
    localparam int INDEX_W        = 17;
    localparam int DATA_W         = 8;
    localparam int FUNC_W         = 2;
    localparam int DEFAULT_WIDTH  = 320;
    localparam int DEFAULT_HEIGHT = 240;

    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 12'h026;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PLOT  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

endpackage

/* design/wfp_store.sv */
module wfp_store
    import wfp_pkg::*;
#(
    parameter int DEPTH = 115200,
    parameter int AW    = 17
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [AW-1:0]     addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Single port: a cycle either writes or reads, and read data is registered.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/wfp_seq.sv */
module wfp_seq
    import wfp_pkg::*;
#(
    parameter int WIDTH  = DEFAULT_WIDTH,
    parameter int HEIGHT = DEFAULT_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [FUNC_W-1:0]      func,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   first,
    input  logic [INDEX_W-1:0]     byte_index,
    input  logic [COLOUR_W-1:0]    colour,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DATA_W-1:0]      m_data,
    output logic                   mem_en,
    output logic                   mem_we,
    output logic [$clog2((3*WIDTH*HEIGHT+1)/2)-1:0] mem_addr,
    output logic [DATA_W-1:0]      mem_wdata,
    input  logic [DATA_W-1:0]      mem_rdata
);

    localparam int STORE_BYTES = (3 * WIDTH * HEIGHT + 1) / 2;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int AW1         = AW + 1;
    localparam int NIB_W       = $clog2(3 * WIDTH * HEIGHT);
    localparam int ROW_W       = $clog2(HEIGHT);
    localparam int COL_W       = $clog2(WIDTH + 1);
    localparam int ROW_STRIDE  = 3 * WIDTH;
    localparam int PROD_W      = SAMPLE_BITS + $clog2(HEIGHT + 1);
    localparam int IW          = (AW > INDEX_W) ? AW1 : INDEX_W + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_ROW    = 8'b0000_0100,
        S_ADDR   = 8'b0000_1000,
        S_PIX_RD = 8'b0001_0000,
        S_PIX_WA = 8'b0010_0000,
        S_PIX_WB = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                   first_reg, first_next;
    logic                   oor_reg, oor_next;
    logic [ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]       hi_row_reg, hi_row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       prev_row_reg, prev_row_next;
    logic [COL_W-1:0]       next_col_reg, next_col_next;
    logic [NIB_W-1:0]       nib_reg, nib_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      out_data_reg, out_data_next;

    logic [PROD_W-1:0]      prod;
    logic [ROW_W-1:0]       row;
    logic [NIB_W-1:0]       nib_calc;
    logic [AW-1:0]          byte_a;
    logic [AW:0]            byte_a1;
    logic                   a1_ok;
    logic                   nib_odd;
    logic                   in_range;

    assign prod     = PROD_W'(sample_reg) * PROD_W'(HEIGHT);
    assign row      = ROW_W'(prod >> SAMPLE_BITS);
    assign nib_calc = NIB_W'(ROW_STRIDE) * NIB_W'(cur_row_reg)
                    + NIB_W'(col_reg) + NIB_W'({col_reg, 1'b0});
    assign nib_odd  = nib_reg[0];
    assign byte_a   = AW'(nib_reg >> 1);
    assign byte_a1  = {1'b0, byte_a} + 1'b1;
    assign a1_ok    = byte_a1 < AW1'(STORE_BYTES);
    assign in_range = IW'(byte_index) < IW'(STORE_BYTES);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        sample_next    = sample_reg;
        first_next     = first_reg;
        oor_next       = oor_reg;
        cur_row_next   = cur_row_reg;
        hi_row_next    = hi_row_reg;
        col_next       = col_reg;
        prev_row_next  = prev_row_reg;
        next_col_next  = next_col_reg;
        nib_next       = nib_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = byte_a;
        mem_wdata      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (func)
                        FUNC_PLOT:
                        begin
                            sample_next = sample;
                            first_next  = first;
                            state_next  = S_ROW;
                        end
                        FUNC_READ:
                        begin
                            oor_next   = !in_range;
                            mem_en     = in_range;
                            mem_addr   = AW'(byte_index);
                            state_next = S_RESP;
                        end
                        FUNC_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_ROW:
            begin
                if (first_reg)
                begin
                    cur_row_next  = row;
                    hi_row_next   = row;
                    col_next      = '0;
                    prev_row_next = row;
                    next_col_next = COL_W'(1);
                    state_next    = S_ADDR;
                end
                else if (next_col_reg < COL_W'(WIDTH))
                begin
                    cur_row_next  = (row < prev_row_reg) ? row : prev_row_reg;
                    hi_row_next   = (row < prev_row_reg) ? prev_row_reg : row;
                    col_next      = next_col_reg;
                    prev_row_next = row;
                    next_col_next = next_col_reg + 1'b1;
                    state_next    = S_ADDR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADDR:
            begin
                nib_next   = nib_calc;
                state_next = S_PIX_RD;
            end
            S_PIX_RD:
            begin
                // Fetch the byte that keeps a nibble of its neighbor.
                mem_en     = nib_odd || a1_ok;
                mem_addr   = nib_odd ? byte_a : AW'(byte_a1);
                state_next = S_PIX_WA;
            end
            S_PIX_WA:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = byte_a;
                mem_wdata  = nib_odd ? {mem_rdata[7:4], colour[11:8]} : colour[11:4];
                state_next = S_PIX_WB;
            end
            S_PIX_WB:
            begin
                // The second byte of the last pixel is the last byte of the store; a1_ok guards it.
                mem_en    = a1_ok;
                mem_we    = 1'b1;
                mem_addr  = AW'(byte_a1);
                mem_wdata = nib_odd ? colour[7:0] : {colour[3:0], mem_rdata[3:0]};
                if (cur_row_reg == hi_row_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                    state_next   = S_ADDR;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = oor_reg ? '0 : mem_rdata;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            prev_row_reg  <= '0;
            next_col_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            prev_row_reg  <= prev_row_next;
            next_col_reg  <= next_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        first_reg    <= first_next;
        oor_reg      <= oor_next;
        cur_row_reg  <= cur_row_next;
        hi_row_reg   <= hi_row_next;
        col_reg      <= col_next;
        nib_reg      <= nib_next;
        out_data_reg <= out_data_next;
    end

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_en && mem_we) |-> ({1'b0, mem_addr} < AW1'(STORE_BYTES)))
        else $error("frame store write beyond the store");

    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_col_reg <= COL_W'(WIDTH))
        else $error("column counter passed the trace width");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIX_RD || state_reg == S_PIX_WA || state_reg == S_PIX_WB)
        |-> (cur_row_reg <= hi_row_reg))
        else $error("span walk passed its top row");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the response step");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_addr_reg == AW'(STORE_BYTES - 1))
        |=> (state_reg == S_IDLE))
        else $error("clear sweep did not stop at the last byte");

endmodule

/* design/waveform_plot_rgb444_framebuffer.sv */
// Plots a sample trace into a packed RGB444 frame store (two pixels per three bytes) and
// serves byte reads of it. Requests enter on s_* with the operation in s_tuser and the
// first-sample mark in s_tlast; read results leave on m_*, and the trace colour is
// written on cfg_*, which is always ready. All work goes through one single-port frame
// memory, one access per cycle: a read request issues its byte read and then a response
// step, a plot request takes a row step and then, for every pixel of the vertical span it
// draws, an address, read and two write steps, and a clear request zeroes all
// (3*WIDTH*HEIGHT+1)/2 bytes of the store. After reset the same clearing pass runs
// before the first request is taken. A read result held in the output register does
// not block the next request; only a second read waits for it to be taken.
module waveform_plot_rgb444_framebuffer
    import wfp_pkg::*;
#(
    parameter int WIDTH  = DEFAULT_WIDTH,
    parameter int HEIGHT = DEFAULT_HEIGHT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // sample [11:0], byte_index [28:12]
    input  logic [FUNC_W-1:0]   s_tuser,   // func [1:0]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // read_data [7:0]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COLOUR_W-1:0] cfg_data
);

    localparam int STORE_BYTES = (3 * WIDTH * HEIGHT + 1) / 2;
    localparam int AW          = $clog2(STORE_BYTES);

    logic [COLOUR_W-1:0] colour_reg;
    logic                mem_en;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [DATA_W-1:0]   mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= COLOUR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            colour_reg <= cfg_data;
        end
    end

    wfp_seq #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .func       (s_tuser),
        .sample     (s_tdata[11:0]),
        .first      (s_tlast),
        .byte_index (s_tdata[28:12]),
        .colour     (colour_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_data     (m_tdata),
        .mem_en     (mem_en),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    wfp_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
